// ===== sv/bil_pkg.sv =====
package bil_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e                  req_type;
    logic signed [IN_VAL_W-1:0] value;
    logic [POS_W-1:0]           position;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [FIDX_W-1:0] found_index;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } out_t;

endpackage

// ===== sv/bounded_integer_list_top.sv =====
// Ordered list of signed values with append, find, delete at index and clear.
// Input channel: in_valid_i, in_data_i and in_stall_o carry one request per
// transaction. Output channel: out_valid_o, out_data_o and out_stall_i carry
// one result per request, in request order.
// The entries live in a single-port-write, single-port-read memory with a
// registered read, so every request is worked through by a sequencer.
// Append and out-of-range deletes go straight to the result. Find reads
// the entries from index 0 up to the first match, or up to the length when
// nothing matches. Delete at position p moves every entry above p down by
// one, and clear zeroes the entries below the length, one entry moved or
// zeroed per cycle through the memory ports.
// A new request is accepted only while the sequencer is idle, which it
// becomes once the result has moved into the output register.
// When the receiver stalls, the result waits in the output register and one
// more request can be worked on; a second finished result is held inside
// until the output register frees up, and the input then stalls.
// Reset empties the list and drops any pending result; stored values are
// not cleared, and entries at or above the length are never read.
module bounded_integer_list_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bil_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bil_pkg::out_t  out_data_o
);
  import bil_pkg::*;

  logic res_valid;
  out_t res;
  logic res_take;
  logic out_valid_q, out_valid_d;
  out_t out_q;

  bil_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_i      (in_data_i),
    .req_stall_o(in_stall_o),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/bil_engine.sv =====
module bil_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  bil_pkg::in_t req_i,
  output logic         req_stall_o,
  output logic         res_valid_o,
  output bil_pkg::out_t res_o,
  input  logic         res_take_i
);
  import bil_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_CLEAR,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  status_e                status_q, status_d;
  logic [IDX_W-1:0]       hit_q, hit_d;

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;

  logic                   issue;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;

  assign issue   = idx_q < count_q;
  assign req_val = VALUE_WIDTH'($unsigned(req_i.value));
  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    key_d     = key_q;
    status_d  = status_q;
    hit_d     = hit_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          hit_d    = '0;
          status_d = ST_OK;
          unique case (req_i.req_type)
            REQ_APPEND: begin
              if (count_q < CNT_W'(DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = req_val;
                count_d   = count_q + CNT_W'(1);
              end else begin
                status_d = ST_FULL;
              end
              state_d = S_DONE;
            end
            REQ_FIND: begin
              key_d   = req_val;
              idx_d   = '0;
              state_d = S_FIND;
            end
            REQ_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                idx_d   = CNT_W'(req_i.position) + CNT_W'(1);
                state_d = S_SHIFT;
              end
            end
            REQ_CLEAR: begin
              idx_d   = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (issue) begin
          mem_re   = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[IDX_W-1:0];
        end
        if (rd_vld_q && (rdata_q == key_q)) begin
          hit_d    = rd_idx_q;
          rd_vld_d = 1'b0;
          state_d  = S_DONE;
        end else if (!issue && !rd_vld_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_SHIFT: begin
        if (issue) begin
          mem_re   = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q - IDX_W'(1);
          mem_wdata = rdata_q;
        end
        if (!issue && !rd_vld_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        if (issue) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[IDX_W-1:0];
          mem_wdata = '0;
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      key_q    <= '0;
      status_q <= ST_OK;
      hit_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      rd_idx_q <= rd_idx_d;
      key_q    <= key_d;
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign req_stall_o       = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.found_index = FIDX_W'(hit_q);
  assign res_o.length      = LEN_W'(count_q);
  assign res_o.is_empty    = (count_q == '0);

`ifndef ASSERT_OFF
  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_vld_q)
    else $error("A memory read is still pending while the engine is idle.");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("The memory is written and read at the same entry.");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_SHIFT))
    else $error("The length changed outside an append or a delete.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (count_q <= CNT_W'(DEPTH)))
    else $error("The length exceeds the list capacity.");
`endif

endmodule
